>>> hdl/lzss_stream_decoder_unit_macros.svh
// Assertion macros used by the decoder unit.
`ifndef LZSS_STREAM_DECODER_UNIT_MACROS_SVH
`define LZSS_STREAM_DECODER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZSSD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZSSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/lzssd_pkg.sv
package lzssd_pkg;

    localparam int WINDOW_SIZE = 4096;
    localparam int WIN_AW = $clog2(WINDOW_SIZE);
    localparam int LEN_W = 5;
    localparam logic [WIN_AW-1:0] CURSOR_START = WIN_AW'(12'hFEE);
    localparam logic [LEN_W-1:0] MIN_MATCH = LEN_W'(3);
    localparam logic [3:0] FLAG_BITS = 4'd8;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COPY
    } dec_state_t;

    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_LITERAL,
        CMD_MATCH
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [7:0]         data;
        logic [WIN_AW-1:0]  src;
        logic [LEN_W-1:0]   len;
    } dec_cmd_t;

endpackage

>>> hdl/lzssd_window_ram.sv
module lzssd_window_ram #(
    parameter int DEPTH  = 4096,
    parameter int DATA_W = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/lzssd_parser.sv
module lzssd_parser (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clear,
    input  logic              accept,
    input  logic [7:0]        byte_in,
    output lzssd_pkg::dec_cmd_t cmd
);
    import lzssd_pkg::*;

    logic [7:0] ctrl_bits_reg, ctrl_bits_next;
    logic [3:0] bits_left_reg, bits_left_next;
    logic       pending_reg, pending_next;
    logic [7:0] low_byte_reg, low_byte_next;

    always_comb begin
        ctrl_bits_next = ctrl_bits_reg;
        bits_left_next = bits_left_reg;
        pending_next   = pending_reg;
        low_byte_next  = low_byte_reg;
        cmd.kind = CMD_NONE;
        cmd.data = byte_in;
        cmd.src  = {byte_in[3:0], low_byte_reg};
        cmd.len  = {1'b0, byte_in[7:4]} + MIN_MATCH;
        if (accept) begin
            if (pending_reg) begin
                cmd.kind       = CMD_MATCH;
                pending_next   = 1'b0;
                low_byte_next  = 8'd0;
                ctrl_bits_next = {ctrl_bits_reg[6:0], 1'b0};
                if (bits_left_reg != 4'd0) begin
                    bits_left_next = bits_left_reg - 4'd1;
                end
            end else if (bits_left_reg == 4'd0) begin
                ctrl_bits_next = byte_in;
                bits_left_next = FLAG_BITS;
            end else if (ctrl_bits_reg[7]) begin
                cmd.kind       = CMD_LITERAL;
                ctrl_bits_next = {ctrl_bits_reg[6:0], 1'b0};
                bits_left_next = bits_left_reg - 4'd1;
            end else begin
                low_byte_next = byte_in;
                pending_next  = 1'b1;
            end
        end
        if (clear) begin
            ctrl_bits_next = 8'd0;
            bits_left_next = 4'd0;
            pending_next   = 1'b0;
            low_byte_next  = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_bits_reg <= 8'd0;
            bits_left_reg <= 4'd0;
            pending_reg   <= 1'b0;
            low_byte_reg  <= 8'd0;
        end else begin
            ctrl_bits_reg <= ctrl_bits_next;
            bits_left_reg <= bits_left_next;
            pending_reg   <= pending_next;
            low_byte_reg  <= low_byte_next;
        end
    end

endmodule

>>> hdl/lzss_stream_decoder_unit.sv
// Channel  | Direction | tdata (low bit up)     | tlast      | Ready depends on
// s_       | in        | compressed_byte [7:0]  | stream_end | idle and output free
// m_       | out       | plain_byte [7:0]       | run_last   | downstream
//
// A flag byte, the first byte of a match and a literal are each taken in the idle state.
// The second byte of a match starts a copy of length bytes (3 to 18), with one window
// read and one write per copied byte through the single read port of the window RAM.
// After reset and after each word marked tlast, a clearing pass writes zeros to the
// whole window, during which no word is accepted.
// A stall on m_ holds the copy; no window write is made and no second read is issued.
module lzss_stream_decoder_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // compressed_byte [7:0]
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // plain_byte [7:0]
    output logic       m_tlast
);
    import lzssd_pkg::*;

    dec_state_t        state_reg, state_next;
    logic [WIN_AW-1:0] cursor_reg, cursor_next;
    logic [WIN_AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [WIN_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LEN_W-1:0]  iss_left_reg, iss_left_next;
    logic [LEN_W-1:0]  emit_left_reg, emit_left_next;
    logic              data_vld_reg, data_vld_next;
    logic              fwd_hit_reg, fwd_hit_next;
    logic [7:0]        fwd_data_reg, fwd_data_next;
    logic              end_pending_reg, end_pending_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    dec_cmd_t          cmd;
    logic              out_free;
    logic              s_accept;
    logic              clearing;
    logic              consume;
    logic              issue;
    logic              lit;
    logic [7:0]        copy_byte;
    logic              ram_we;
    logic [WIN_AW-1:0] ram_wa;
    logic [7:0]        ram_wd;
    logic [7:0]        ram_rd;

    lzssd_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clear   (clearing),
        .accept  (s_accept),
        .byte_in (s_tdata),
        .cmd     (cmd)
    );

    lzssd_window_ram #(
        .DEPTH  (WINDOW_SIZE),
        .DATA_W (8)
    ) u_window (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_wa),
        .wr_data (ram_wd),
        .rd_en   (issue),
        .rd_addr (rd_ptr_reg),
        .rd_data (ram_rd)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign s_accept  = s_tvalid && s_tready;
    assign copy_byte = fwd_hit_reg ? fwd_data_reg : ram_rd;
    assign lit       = s_accept && (cmd.kind == CMD_LITERAL);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_cnt_reg == WIN_AW'(WINDOW_SIZE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (cmd.kind == CMD_MATCH) begin
                        state_next = ST_COPY;
                    end else if (s_tlast) begin
                        state_next = ST_CLEAR;
                    end
                end
            end
            ST_COPY: begin
                if (consume && (emit_left_reg == LEN_W'(1))) begin
                    state_next = end_pending_reg ? ST_CLEAR : ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        clearing = 1'b0;
        consume  = 1'b0;
        issue    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                clearing = 1'b1;
            end
            ST_IDLE: begin
                s_tready = out_free;
            end
            ST_COPY: begin
                consume = data_vld_reg && out_free;
                issue   = (iss_left_reg != '0) && (!data_vld_reg || consume);
            end
            default: clearing = 1'b1;
        endcase
        ram_we = clearing || lit || consume;
        ram_wa = clearing ? clr_cnt_reg : cursor_reg;
        ram_wd = clearing ? 8'd0 : (lit ? cmd.data : copy_byte);
    end

    always_comb begin
        cursor_next      = cursor_reg;
        clr_cnt_next     = clearing ? clr_cnt_reg + WIN_AW'(1) : '0;
        rd_ptr_next      = rd_ptr_reg;
        iss_left_next    = iss_left_reg;
        emit_left_next   = emit_left_reg;
        data_vld_next    = data_vld_reg;
        fwd_hit_next     = fwd_hit_reg;
        fwd_data_next    = fwd_data_reg;
        end_pending_next = end_pending_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        out_last_next    = out_last_reg;

        if (clearing) begin
            cursor_next      = CURSOR_START;
            end_pending_next = 1'b0;
        end else if (lit || consume) begin
            cursor_next = cursor_reg + WIN_AW'(1);
        end

        if (s_accept && (cmd.kind == CMD_MATCH)) begin
            rd_ptr_next      = cmd.src;
            iss_left_next    = cmd.len;
            emit_left_next   = cmd.len;
            end_pending_next = s_tlast;
        end

        if (issue) begin
            rd_ptr_next   = rd_ptr_reg + WIN_AW'(1);
            iss_left_next = iss_left_reg - LEN_W'(1);
            fwd_hit_next  = consume && (rd_ptr_reg == cursor_reg);
            fwd_data_next = copy_byte;
            data_vld_next = 1'b1;
        end else if (consume) begin
            data_vld_next = 1'b0;
        end

        if (consume) begin
            emit_left_next = emit_left_reg - LEN_W'(1);
        end

        if (lit) begin
            out_valid_next = 1'b1;
            out_data_next  = cmd.data;
            out_last_next  = 1'b1;
        end else if (consume) begin
            out_valid_next = 1'b1;
            out_data_next  = copy_byte;
            out_last_next  = (emit_left_reg == LEN_W'(1));
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            cursor_reg      <= CURSOR_START;
            clr_cnt_reg     <= '0;
            iss_left_reg    <= '0;
            emit_left_reg   <= '0;
            data_vld_reg    <= 1'b0;
            fwd_hit_reg     <= 1'b0;
            end_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            cursor_reg      <= cursor_next;
            clr_cnt_reg     <= clr_cnt_next;
            iss_left_reg    <= iss_left_next;
            emit_left_reg   <= emit_left_next;
            data_vld_reg    <= data_vld_next;
            fwd_hit_reg     <= fwd_hit_next;
            end_pending_reg <= end_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_ptr_reg   <= rd_ptr_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`include "lzss_stream_decoder_unit_macros.svh"

    `LZSSD_ASSERT_SAME(a_one_in_flight, 1'b1,
        (emit_left_reg == iss_left_reg) || (emit_left_reg == iss_left_reg + LEN_W'(1)),
        "copy read and emit counters drifted apart")
    `LZSSD_ASSERT_SAME(a_consume_counted, consume, emit_left_reg != '0,
        "copy byte emitted with no bytes left")
    `LZSSD_ASSERT_NEXT(a_copy_ends, consume && (emit_left_reg == LEN_W'(1)),
        (state_reg != ST_COPY) && !data_vld_reg,
        "copy did not finish after its last byte")

endmodule
